>>> design/blm_pkg.sv
// Package for the battery level monitor: widths, codes, reset values,
// and the request/response types of the shared divider. No dependencies.
package blm_pkg;

   localparam int FIFO_DEPTH_DEF = 8;
   localparam int AVG_COUNT_DEF  = 3;

   localparam int FUNC_W     = 2;
   localparam int ADC_W      = 12;
   localparam int STAMP_W    = 16;
   localparam int VOLT_W     = 12;
   localparam int PCT_W      = 7;
   localparam int GAIN_W     = 24;
   localparam int THR_W      = 9;
   localparam int HOLD_W     = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int PROD_W     = ADC_W + GAIN_W;
   localparam int PNUM_W     = 19;
   localparam int DIFF_W     = VOLT_W + 1;

   // item kinds
   localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_REARM  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_VOLT_GAIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CUTOFF      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_CHG    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_DIS    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RISE_THR    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FALL_THR    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_ENTER   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_EXIT    = 3'd7;

   // register reset values
   localparam logic [GAIN_W-1:0] GAIN_RST      = 24'd2411110;
   localparam logic [VOLT_W-1:0] CUTOFF_RST    = 12'd560;
   localparam logic [VOLT_W-1:0] FULL_CHG_RST  = 12'd705;
   localparam logic [VOLT_W-1:0] FULL_DIS_RST  = 12'd655;
   localparam logic [THR_W-1:0]  RISE_THR_RST  = 9'd10;
   localparam logic [THR_W-1:0]  FALL_THR_RST  = 9'd3;
   localparam logic [PCT_W-1:0]  LOW_ENTER_RST = 7'd10;
   localparam logic [PCT_W-1:0]  LOW_EXIT_RST  = 7'd30;

   localparam logic [VOLT_W-1:0] REF_RST     = 12'd655;
   localparam logic [HOLD_W-1:0] HOLD_INIT   = 8'hFF;
   localparam logic [HOLD_W-1:0] HOLD_TICKS  = 8'd10;
   localparam logic [VOLT_W-1:0] VOLT_MAX    = 12'd4095;
   localparam logic [PCT_W-1:0]  PCT_SCALE   = 7'd100;

   // Q8 gain times 10000 scale: 256 * 10000
   localparam int DIV_NUM_W = PROD_W;
   localparam int DIV_DEN_W = 22;
   localparam int DIV_Q_W   = 12;
   localparam int DIV_CNT_W = 4;
   localparam logic [DIV_DEN_W-1:0] VOLT_DIV  = 22'd2560000;
   // products at or above 4096 * VOLT_DIV saturate
   localparam logic [PROD_W-1:0]    SAT_LIMIT = 36'd10485760000;

   localparam logic [DIV_CNT_W-1:0] NB_AVG  = 4'd12;
   localparam logic [DIV_CNT_W-1:0] NB_VOLT = 4'd12;
   localparam logic [DIV_CNT_W-1:0] NB_PCT  = 4'd7;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
      logic [DIV_CNT_W-1:0] nbits;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_Q_W-1:0] quot;
   } div_rsp_type;

endpackage

>>> design/blm_ifs.sv
// Channel interfaces of the battery level monitor: request, response, CSR write.
// Depends on blm_pkg for field widths.
interface blm_req_if;
   import blm_pkg::*;
   logic               valid;
   logic               ready;
   logic [FUNC_W-1:0]  func;
   logic [ADC_W-1:0]   adc_sample;
   logic [STAMP_W-1:0] tick_stamp;
   modport source (output valid, func, adc_sample, tick_stamp, input ready);
   modport sink   (input valid, func, adc_sample, tick_stamp, output ready);
endinterface

interface blm_rsp_if;
   import blm_pkg::*;
   logic              valid;
   logic              ready;
   logic [VOLT_W-1:0] battery_volt;
   logic [PCT_W-1:0]  percent_left;
   logic              charging;
   logic              low_battery;
   logic              below_cutoff;
   logic              updated;
   logic              sample_dropped;
   modport source (output valid, battery_volt, percent_left, charging, low_battery,
                   below_cutoff, updated, sample_dropped, input ready);
   modport sink   (input valid, battery_volt, percent_left, charging, low_battery,
                   below_cutoff, updated, sample_dropped, output ready);
endinterface

interface blm_csr_if;
   import blm_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> design/blm_div.sv
// Shared restoring divider, one quotient bit per cycle, quotient width set per request.
// Depends on blm_pkg (div_req_type, div_rsp_type).
module blm_div (
   input  logic                 clock,
   input  logic                 reset,
   input  blm_pkg::div_req_type req,
   output blm_pkg::div_rsp_type rsp
);
   import blm_pkg::*;

   logic [DIV_NUM_W-1:0] rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] dsh_ff, dsh_in;
   logic [DIV_Q_W-1:0]   quot_ff, quot_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 sub_ok;

   assign sub_ok = rem_ff >= dsh_ff;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = req.num;
         dsh_in  = DIV_NUM_W'(req.den) << (req.nbits - DIV_CNT_W'(1));
         quot_in = '0;
         cnt_in  = req.nbits;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = sub_ok ? rem_ff - dsh_ff : rem_ff;
         dsh_in  = dsh_ff >> 1;
         quot_in = {quot_ff[DIV_Q_W-2:0], sub_ok};
         cnt_in  = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

endmodule

>>> design/battery_level_monitor.sv
// Battery level monitor top level. Samples, rearms, stale and short ticks go through
// multiply, voltage divide and percent divide; an averaging tick first sums and divides
// AVG_COUNT samples and adds slope decision and low-battery update. Saturation skips the
// voltage divide, full not above cut-off the percent divide. One transaction at a time:
// the next is accepted at the earliest in the cycle its response shows.
// Synchronous active-high reset: empty FIFO, state and registers at reset values.
module battery_level_monitor #(
   parameter int FIFO_DEPTH = blm_pkg::FIFO_DEPTH_DEF,
   parameter int AVG_COUNT  = blm_pkg::AVG_COUNT_DEF
) (
   input logic        clock,
   input logic        reset,
   blm_req_if.sink    req_chan,
   blm_rsp_if.source  rsp_chan,
   blm_csr_if.sink    csr_chan
);
   import blm_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam int SUM_W = ADC_W + $clog2(AVG_COUNT);
   localparam int SC_W  = $clog2(AVG_COUNT + 1);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_SUM     = 4'd1;
   localparam logic [3:0] S_AVG_GO  = 4'd2;
   localparam logic [3:0] S_AVG_WT  = 4'd3;
   localparam logic [3:0] S_MUL     = 4'd4;
   localparam logic [3:0] S_VOLT_GO = 4'd5;
   localparam logic [3:0] S_VOLT_WT = 4'd6;
   localparam logic [3:0] S_DECIDE  = 4'd7;
   localparam logic [3:0] S_PCT_GO  = 4'd8;
   localparam logic [3:0] S_PCT_WT  = 4'd9;
   localparam logic [3:0] S_LOW     = 4'd10;
   localparam logic [3:0] S_DONE    = 4'd11;

   logic [3:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [ADC_W-1:0]  avg_ff, avg_in;
   logic [VOLT_W-1:0] ref_ff, ref_in;
   logic              chg_ff, chg_in;
   logic [HOLD_W-1:0] hold_ff, hold_in;
   logic              low_ff, low_in;
   logic [STAMP_W-1:0] stamp_ff, stamp_in;
   logic              upd_ff, upd_in;
   logic              drop_ff, drop_in;
   logic [SC_W-1:0]   sc_ff, sc_in;

   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic [VOLT_W-1:0] cut_ff, cut_in;
   logic [VOLT_W-1:0] fchg_ff, fchg_in;
   logic [VOLT_W-1:0] fdis_ff, fdis_in;
   logic [THR_W-1:0]  rise_ff, rise_in;
   logic [THR_W-1:0]  fall_ff, fall_in;
   logic [PCT_W-1:0]  lent_ff, lent_in;
   logic [PCT_W-1:0]  lext_ff, lext_in;

   // payload registers
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [VOLT_W-1:0] volt_ff, volt_in;
   logic [PCT_W-1:0]  pct_ff, pct_in;
   logic [ADC_W-1:0]  rd_data_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [VOLT_W-1:0] rsp_volt_ff, rsp_volt_in;
   logic [PCT_W-1:0]  rsp_pct_ff, rsp_pct_in;
   logic              rsp_chg_ff, rsp_chg_in;
   logic              rsp_low_ff, rsp_low_in;
   logic              rsp_below_ff, rsp_below_in;
   logic              rsp_upd_ff, rsp_upd_in;
   logic              rsp_drop_ff, rsp_drop_in;

   logic [ADC_W-1:0]  fifo_mem [FIFO_DEPTH];

   div_req_type       div_req;
   div_rsp_type       div_rsp;

   logic              req_fire;
   logic              push;
   logic              fifo_full;
   logic [VOLT_W-1:0] full_v;
   logic [VOLT_W-1:0] vclamp;
   logic signed [DIFF_W-1:0] diff;
   logic signed [DIFF_W-1:0] rise_x;
   logic signed [DIFF_W-1:0] fall_x;

   blm_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_fire  = req_chan.valid && req_chan.ready;
   assign fifo_full = (count_ff >= CNT_W'(FIFO_DEPTH));
   assign push      = req_fire && (req_chan.func == FUNC_SAMPLE) && !fifo_full;

   assign full_v = chg_ff ? fchg_ff : fdis_ff;
   assign vclamp = (volt_ff < cut_ff) ? cut_ff : ((volt_ff > full_v) ? full_v : volt_ff);
   assign diff   = $signed({1'b0, volt_ff}) - $signed({1'b0, ref_ff});
   assign rise_x = $signed({{(DIFF_W-THR_W){rise_ff[THR_W-1]}}, rise_ff});
   assign fall_x = $signed({{(DIFF_W-THR_W){fall_ff[THR_W-1]}}, fall_ff});

   // configuration writes
   always_comb begin
      gain_in = gain_ff;
      cut_in  = cut_ff;
      fchg_in = fchg_ff;
      fdis_in = fdis_ff;
      rise_in = rise_ff;
      fall_in = fall_ff;
      lent_in = lent_ff;
      lext_in = lext_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_VOLT_GAIN: gain_in = csr_chan.data[GAIN_W-1:0];
            CSR_CUTOFF:    cut_in  = csr_chan.data[VOLT_W-1:0];
            CSR_FULL_CHG:  fchg_in = csr_chan.data[VOLT_W-1:0];
            CSR_FULL_DIS:  fdis_in = csr_chan.data[VOLT_W-1:0];
            CSR_RISE_THR:  rise_in = csr_chan.data[THR_W-1:0];
            CSR_FALL_THR:  fall_in = csr_chan.data[THR_W-1:0];
            CSR_LOW_ENTER: lent_in = csr_chan.data[PCT_W-1:0];
            CSR_LOW_EXIT:  lext_in = csr_chan.data[PCT_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      avg_in   = avg_ff;
      ref_in   = ref_ff;
      chg_in   = chg_ff;
      hold_in  = hold_ff;
      low_in   = low_ff;
      stamp_in = stamp_ff;
      upd_in   = upd_ff;
      drop_in  = drop_ff;
      sc_in    = sc_ff;
      sum_in   = sum_ff;
      prod_in  = prod_ff;
      volt_in  = volt_ff;
      pct_in   = pct_ff;
      div_req  = '0;

      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_volt_in  = rsp_volt_ff;
      rsp_pct_in   = rsp_pct_ff;
      rsp_chg_in   = rsp_chg_ff;
      rsp_low_in   = rsp_low_ff;
      rsp_below_in = rsp_below_ff;
      rsp_upd_in   = rsp_upd_ff;
      rsp_drop_in  = rsp_drop_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               upd_in   = 1'b0;
               drop_in  = 1'b0;
               sum_in   = '0;
               sc_in    = '0;
               state_in = S_MUL;
               case (req_chan.func)
                  FUNC_SAMPLE: begin
                     if (fifo_full) begin
                        drop_in = 1'b1;
                     end else begin
                        count_in = count_ff + CNT_W'(1);
                        tail_in  = (tail_ff == PTR_W'(FIFO_DEPTH - 1)) ?
                                   '0 : tail_ff + PTR_W'(1);
                     end
                  end
                  FUNC_TICK: begin
                     if (req_chan.tick_stamp != stamp_ff) begin
                        stamp_in = req_chan.tick_stamp;
                        if (count_ff >= CNT_W'(AVG_COUNT)) begin
                           upd_in   = 1'b1;
                           count_in = count_ff - CNT_W'(AVG_COUNT);
                           state_in = S_SUM;
                        end
                     end
                  end
                  FUNC_REARM: begin
                     if (hold_ff != HOLD_INIT) begin
                        hold_in = HOLD_TICKS;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SUM: begin
            // read data is registered, so it follows the pointer in the next cycle
            if (sc_ff != '0) begin
               sum_in = sum_ff + SUM_W'(rd_data_ff);
            end
            if (sc_ff == SC_W'(AVG_COUNT)) begin
               state_in = S_AVG_GO;
            end else begin
               sc_in   = sc_ff + SC_W'(1);
               head_in = (head_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
            end
         end
         S_AVG_GO: begin
            div_req.start = 1'b1;
            div_req.num   = DIV_NUM_W'(sum_ff);
            div_req.den   = DIV_DEN_W'(AVG_COUNT);
            div_req.nbits = NB_AVG;
            state_in      = S_AVG_WT;
         end
         S_AVG_WT: begin
            if (div_rsp.done) begin
               avg_in   = div_rsp.quot[ADC_W-1:0];
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = PROD_W'(avg_ff) * PROD_W'(gain_ff);
            state_in = S_VOLT_GO;
         end
         S_VOLT_GO: begin
            if (prod_ff >= SAT_LIMIT) begin
               volt_in  = VOLT_MAX;
               state_in = upd_ff ? S_DECIDE : S_PCT_GO;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = prod_ff;
               div_req.den   = VOLT_DIV;
               div_req.nbits = NB_VOLT;
               state_in      = S_VOLT_WT;
            end
         end
         S_VOLT_WT: begin
            if (div_rsp.done) begin
               volt_in  = div_rsp.quot[VOLT_W-1:0];
               state_in = upd_ff ? S_DECIDE : S_PCT_GO;
            end
         end
         S_DECIDE: begin
            if (hold_ff == '0 || hold_ff == HOLD_INIT) begin
               hold_in = '0;
               if (diff > rise_x) begin
                  chg_in = 1'b1;
                  ref_in = volt_ff;
               end else if (diff < fall_x) begin
                  chg_in = 1'b0;
                  ref_in = volt_ff;
               end
            end else begin
               hold_in = hold_ff - HOLD_W'(1);
               ref_in  = volt_ff;
            end
            state_in = S_PCT_GO;
         end
         S_PCT_GO: begin
            if (full_v <= cut_ff) begin
               pct_in   = '0;
               state_in = upd_ff ? S_LOW : S_DONE;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = DIV_NUM_W'(PNUM_W'(vclamp - cut_ff) * PNUM_W'(PCT_SCALE));
               div_req.den   = DIV_DEN_W'(full_v - cut_ff);
               div_req.nbits = NB_PCT;
               state_in      = S_PCT_WT;
            end
         end
         S_PCT_WT: begin
            if (div_rsp.done) begin
               pct_in   = div_rsp.quot[PCT_W-1:0];
               state_in = upd_ff ? S_LOW : S_DONE;
            end
         end
         S_LOW: begin
            if (pct_ff < lent_ff) begin
               low_in = 1'b1;
            end else if (pct_ff >= lext_ff) begin
               low_in = 1'b0;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_volt_in  = volt_ff;
               rsp_pct_in   = pct_ff;
               rsp_chg_in   = chg_ff;
               rsp_low_in   = low_ff;
               rsp_below_in = volt_ff < cut_ff;
               rsp_upd_in   = upd_ff;
               rsp_drop_in  = drop_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         avg_ff       <= '0;
         ref_ff       <= REF_RST;
         chg_ff       <= 1'b0;
         hold_ff      <= HOLD_INIT;
         low_ff       <= 1'b0;
         stamp_ff     <= '0;
         upd_ff       <= 1'b0;
         drop_ff      <= 1'b0;
         sc_ff        <= '0;
         gain_ff      <= GAIN_RST;
         cut_ff       <= CUTOFF_RST;
         fchg_ff      <= FULL_CHG_RST;
         fdis_ff      <= FULL_DIS_RST;
         rise_ff      <= RISE_THR_RST;
         fall_ff      <= FALL_THR_RST;
         lent_ff      <= LOW_ENTER_RST;
         lext_ff      <= LOW_EXIT_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         avg_ff       <= avg_in;
         ref_ff       <= ref_in;
         chg_ff       <= chg_in;
         hold_ff      <= hold_in;
         low_ff       <= low_in;
         stamp_ff     <= stamp_in;
         upd_ff       <= upd_in;
         drop_ff      <= drop_in;
         sc_ff        <= sc_in;
         gain_ff      <= gain_in;
         cut_ff       <= cut_in;
         fchg_ff      <= fchg_in;
         fdis_ff      <= fdis_in;
         rise_ff      <= rise_in;
         fall_ff      <= fall_in;
         lent_ff      <= lent_in;
         lext_ff      <= lext_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff       <= sum_in;
      prod_ff      <= prod_in;
      volt_ff      <= volt_in;
      pct_ff       <= pct_in;
      rsp_volt_ff  <= rsp_volt_in;
      rsp_pct_ff   <= rsp_pct_in;
      rsp_chg_ff   <= rsp_chg_in;
      rsp_low_ff   <= rsp_low_in;
      rsp_below_ff <= rsp_below_in;
      rsp_upd_ff   <= rsp_upd_in;
      rsp_drop_ff  <= rsp_drop_in;
   end

   // sample FIFO storage
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[tail_ff] <= req_chan.adc_sample;
      end
      rd_data_ff <= fifo_mem[head_ff];
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.battery_volt   = rsp_volt_ff;
   assign rsp_chan.percent_left   = rsp_pct_ff;
   assign rsp_chan.charging       = rsp_chg_ff;
   assign rsp_chan.low_battery    = rsp_low_ff;
   assign rsp_chan.below_cutoff   = rsp_below_ff;
   assign rsp_chan.updated        = rsp_upd_ff;
   assign rsp_chan.sample_dropped = rsp_drop_ff;

endmodule

>>> design/blm_checker.sv
// Port-level checks on the battery level monitor's response channel, and the bind
// that attaches them to the top level. Depends on blm_pkg.
module blm_port_checks (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [blm_pkg::VOLT_W-1:0] battery_volt,
   input logic [blm_pkg::PCT_W-1:0]  percent_left,
   input logic                       charging,
   input logic                       low_battery,
   input logic                       below_cutoff,
   input logic                       updated,
   input logic                       sample_dropped
);
   import blm_pkg::*;

   // a stalled transaction holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(battery_volt) &&
      $stable(percent_left) && $stable(charging) && $stable(low_battery) &&
      $stable(below_cutoff) && $stable(updated) && $stable(sample_dropped))
      else $error("response changed while stalled");

   // updated comes only from a tick, sample_dropped only from a sample, so never both
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(updated && sample_dropped))
      else $error("updated and sample_dropped both set");

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> percent_left <= PCT_SCALE)
      else $error("percent above 100");

   // voltage under cut-off clamps to cut-off, which is zero percent
   a_cutoff_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && below_cutoff |-> percent_left == '0)
      else $error("nonzero percent below cut-off");

endmodule

bind battery_level_monitor blm_port_checks u_blm_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .battery_volt   (rsp_chan.battery_volt),
   .percent_left   (rsp_chan.percent_left),
   .charging       (rsp_chan.charging),
   .low_battery    (rsp_chan.low_battery),
   .below_cutoff   (rsp_chan.below_cutoff),
   .updated        (rsp_chan.updated),
   .sample_dropped (rsp_chan.sample_dropped)
);

>>> tb/sv/blm_checker.sv
// Response checker for the battery level monitor: tracks register writes and requests,
// predicts every response and compares it with what the block returns.
// Depends on blm_pkg and the channel interfaces in blm_ifs.
module blm_checker (
   input  logic clock,
   input  logic reset,
   blm_req_if   req_mon,
   blm_rsp_if   rsp_mon,
   blm_csr_if   csr_mon,
   output int   mismatch_count,
   output int   waiting
);
   timeunit 1ns;
   timeprecision 1ps;
   import blm_pkg::*;

   typedef struct packed {
      logic [VOLT_W-1:0] volt;
      logic [PCT_W-1:0]  pct;
      logic              charging;
      logic              low;
      logic              below;
      logic              updated;
      logic              dropped;
   } status_type;

   status_type status_q[$];

   // shadow of the block state
   logic [ADC_W-1:0]   fifo_mem [FIFO_DEPTH_DEF];
   int unsigned        head;
   int unsigned        count;
   logic [ADC_W-1:0]   avg_adc;
   logic [VOLT_W-1:0]  ref_volt;
   logic               chg;
   logic [HOLD_W-1:0]  holdoff;
   logic               low_flag;
   logic [STAMP_W-1:0] last_stamp;

   // shadow of the registers
   logic [GAIN_W-1:0]  gain;
   logic [VOLT_W-1:0]  cutoff;
   logic [VOLT_W-1:0]  full_chg;
   logic [VOLT_W-1:0]  full_dis;
   logic [THR_W-1:0]   rise_thr;
   logic [THR_W-1:0]   fall_thr;
   logic [PCT_W-1:0]   low_enter;
   logic [PCT_W-1:0]   low_exit;

   function automatic logic [VOLT_W-1:0] scaled_volt();
      logic [63:0] p;
      p = 64'(avg_adc) * 64'(gain);
      p = p / 64'(VOLT_DIV);
      return (p > 64'(VOLT_MAX)) ? VOLT_MAX : p[VOLT_W-1:0];
   endfunction

   function automatic logic [PCT_W-1:0] level_percent(logic [VOLT_W-1:0] v);
      int unsigned top_v;
      int unsigned vc;
      top_v = chg ? full_chg : full_dis;
      if (top_v <= cutoff) return '0;
      vc = v;
      if (vc < cutoff) vc = cutoff;
      else if (vc > top_v) vc = top_v;
      return PCT_W'((vc - cutoff) * 100 / (top_v - cutoff));
   endfunction

   function automatic status_type next_status(logic [FUNC_W-1:0] fn,
                                              logic [ADC_W-1:0] smp,
                                              logic [STAMP_W-1:0] stp);
      status_type        s;
      logic [VOLT_W-1:0] v;
      logic [PCT_W-1:0]  p;
      int unsigned       sum;
      int                diff;
      int                i;
      s = '0;
      case (fn)
         FUNC_SAMPLE: begin
            if (count >= FIFO_DEPTH_DEF) begin
               s.dropped = 1'b1;
            end else begin
               fifo_mem[(head + count) % FIFO_DEPTH_DEF] = smp;
               count++;
            end
         end
         FUNC_TICK: begin
            if (stp != last_stamp) begin
               last_stamp = stp;
               if (count >= AVG_COUNT_DEF) begin
                  sum = 0;
                  for (i = 0; i < AVG_COUNT_DEF; i++) begin
                     sum += fifo_mem[head];
                     head = (head + 1) % FIFO_DEPTH_DEF;
                  end
                  count -= AVG_COUNT_DEF;
                  avg_adc = ADC_W'(sum / AVG_COUNT_DEF);
                  s.updated = 1'b1;
                  v = scaled_volt();
                  if (holdoff == '0 || holdoff == HOLD_INIT) begin
                     // slope decision against the reference
                     diff = int'(v) - int'(ref_volt);
                     holdoff = '0;
                     if (diff > int'($signed(rise_thr))) begin
                        chg = 1'b1;
                        ref_volt = v;
                     end else if (diff < int'($signed(fall_thr))) begin
                        chg = 1'b0;
                        ref_volt = v;
                     end
                  end else begin
                     holdoff--;
                     ref_volt = v;
                  end
                  p = level_percent(v);
                  if (p < low_enter) low_flag = 1'b1;
                  else if (p >= low_exit) low_flag = 1'b0;
               end
            end
         end
         FUNC_REARM: begin
            if (holdoff != HOLD_INIT) holdoff = HOLD_TICKS;
         end
         default: ;
      endcase
      v = scaled_volt();
      s.volt     = v;
      s.pct      = level_percent(v);
      s.charging = chg;
      s.low      = low_flag;
      s.below    = (v < cutoff);
      return s;
   endfunction

   always @(posedge clock) begin
      status_type got;
      status_type want;
      if (reset) begin
         status_q.delete();
         mismatch_count = 0;
         head       = 0;
         count      = 0;
         avg_adc    = '0;
         ref_volt   = REF_RST;
         chg        = 1'b0;
         holdoff    = HOLD_INIT;
         low_flag   = 1'b0;
         last_stamp = '0;
         gain       = GAIN_RST;
         cutoff     = CUTOFF_RST;
         full_chg   = FULL_CHG_RST;
         full_dis   = FULL_DIS_RST;
         rise_thr   = RISE_THR_RST;
         fall_thr   = FALL_THR_RST;
         low_enter  = LOW_ENTER_RST;
         low_exit   = LOW_EXIT_RST;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.battery_volt, rsp_mon.percent_left, rsp_mon.charging,
                   rsp_mon.low_battery, rsp_mon.below_cutoff, rsp_mon.updated,
                   rsp_mon.sample_dropped};
            if (status_q.size() == 0) begin
               $display("%0t unexpected response: volt=%0d pct=%0d chg=%b low=%b",
                        $time, got.volt, got.pct, got.charging, got.low,
                        " below=%b upd=%b drop=%b", got.below, got.updated, got.dropped);
               mismatch_count++;
            end else begin
               want = status_q.pop_front();
               if (got !== want) begin
                  $display("%0t mismatch: expected volt=%0d pct=%0d chg=%b low=%b",
                           $time, want.volt, want.pct, want.charging, want.low,
                           " below=%b upd=%b drop=%b", want.below, want.updated,
                           want.dropped);
                  $display("%0t            actual volt=%0d pct=%0d chg=%b low=%b",
                           $time, got.volt, got.pct, got.charging, got.low,
                           " below=%b upd=%b drop=%b", got.below, got.updated,
                           got.dropped);
                  mismatch_count++;
               end
            end
         end
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_VOLT_GAIN: gain      = csr_mon.data[GAIN_W-1:0];
               CSR_CUTOFF:    cutoff    = csr_mon.data[VOLT_W-1:0];
               CSR_FULL_CHG:  full_chg  = csr_mon.data[VOLT_W-1:0];
               CSR_FULL_DIS:  full_dis  = csr_mon.data[VOLT_W-1:0];
               CSR_RISE_THR:  rise_thr  = csr_mon.data[THR_W-1:0];
               CSR_FALL_THR:  fall_thr  = csr_mon.data[THR_W-1:0];
               CSR_LOW_ENTER: low_enter = csr_mon.data[PCT_W-1:0];
               CSR_LOW_EXIT:  low_exit  = csr_mon.data[PCT_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            status_q.push_back(next_status(req_mon.func, req_mon.adc_sample,
                                           req_mon.tick_stamp));
         end
      end
      waiting = status_q.size();
   end

endmodule

>>> tb/sv/tb_top.sv
// Top of the battery level monitor testbench: clock, reset, request and register
// stimulus, response back-pressure, watchdog and verdict. Uses blm_pkg, blm_ifs,
// blm_checker and the battery_level_monitor RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import blm_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int LONG_HOLD   = 400;
   localparam int STALL_LIMIT = 3000;
   localparam int SETTLE      = 60;
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 130;

   logic clock = 1'b0;
   logic reset;

   blm_req_if req_chan ();
   blm_rsp_if rsp_chan ();
   blm_csr_if csr_chan ();

   int mismatches;
   int results_due;

   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned hold_requests = 0;
   int unsigned quiet_cycles;

   int adc_level;
   int drift;
   logic [STAMP_W-1:0] stamp_next;
   logic [STAMP_W-1:0] last_sent_stamp;

   battery_level_monitor i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   blm_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_mon        (csr_chan),
      .mismatch_count (mismatches),
      .waiting        (results_due)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response back-pressure; a new hold request starts a long stretch of ready low
   initial begin
      int unsigned seen;
      int unsigned left;
      seen = 0;
      left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != seen) begin
            seen = hold_requests;
            left = LONG_HOLD;
         end
         if (left != 0) begin
            left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [ADC_W-1:0] smp,
                            input logic [STAMP_W-1:0] stp);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.func       <= fn;
      req_chan.adc_sample <= smp;
      req_chan.tick_stamp <= stp;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic send_tick(input logic [STAMP_W-1:0] stp);
      send_item(FUNC_TICK, ADC_W'($urandom), stp);
      last_sent_stamp = stp;
   endtask

   // sample near the current battery level
   task automatic send_sample();
      int s;
      s = adc_level + int'($urandom_range(12)) - 6;
      if (s < 0) s = 0;
      if (s > 4095) s = 4095;
      send_item(FUNC_SAMPLE, ADC_W'(s), STAMP_W'($urandom));
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= val;
      do @(posedge clock); while (!csr_chan.ready);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // register value in the low bits, random garbage above half the time
   function automatic logic [CSR_DATA_W-1:0] pad_upper(input int v, input int w);
      logic [CSR_DATA_W-1:0] m;
      logic [CSR_DATA_W-1:0] j;
      m = (CSR_DATA_W'(1) << w) - CSR_DATA_W'(1);
      j = ($urandom_range(1) == 0) ? '0 : CSR_DATA_W'($urandom);
      return (CSR_DATA_W'(v) & m) | (j & ~m);
   endfunction

   task automatic program_regs(input int gain, input int cut, input int fchg, input int fdis,
                               input int rise, input int fall, input int enter, input int leave);
      write_reg(CSR_VOLT_GAIN, pad_upper(gain, GAIN_W));
      write_reg(CSR_CUTOFF,    pad_upper(cut, VOLT_W));
      write_reg(CSR_FULL_CHG,  pad_upper(fchg, VOLT_W));
      write_reg(CSR_FULL_DIS,  pad_upper(fdis, VOLT_W));
      write_reg(CSR_RISE_THR,  pad_upper(rise, THR_W));
      write_reg(CSR_FALL_THR,  pad_upper(fall, THR_W));
      write_reg(CSR_LOW_ENTER, pad_upper(enter, PCT_W));
      write_reg(CSR_LOW_EXIT,  pad_upper(leave, PCT_W));
   endtask

   task automatic program_phase(input int phase);
      int cut;
      int fdis;
      int enter;
      int leave;
      case (phase)
         0: program_regs(GAIN_RST, CUTOFF_RST, FULL_CHG_RST, FULL_DIS_RST,
                         int'($signed(RISE_THR_RST)), int'($signed(FALL_THR_RST)),
                         LOW_ENTER_RST, LOW_EXIT_RST);
         4: program_regs(0, 0, 4095, 4095, -256, 255, 0, 0);
         5: program_regs(16777215, 4095, 0, 0, 255, -256, 100, 100);
         // full voltage not above cut-off in both charge states
         6: program_regs(GAIN_RST, 600, 600, 580, int'($urandom_range(20)) - 5, 3, 20, 40);
         default: begin
            cut   = $urandom_range(400, 650);
            fdis  = cut + int'($urandom_range(220)) - 20;
            enter = $urandom_range(50);
            leave = enter + int'($urandom_range(60));
            if (leave > 100) leave = 100;
            if ($urandom_range(9) == 0) leave = $urandom_range(100);
            program_regs($urandom_range(1900000, 2900000), cut,
                         fdis + int'($urandom_range(80)), fdis,
                         int'($urandom_range(30)) - 5, int'($urandom_range(20)) - 10,
                         enter, leave);
         end
      endcase
   endtask

   task automatic drain();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (results_due != 0) @(negedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic run_directed();
      send_tick(16'd0);                                // same stamp as after reset
      send_item(FUNC_REARM, 12'hFFF, 16'hFFFF);        // ignored in the initial state
      send_tick(16'd1);                                // too few samples
      send_item(FUNC_SAMPLE, 12'd0, 16'h0000);
      send_item(FUNC_SAMPLE, 12'd4095, 16'hFFFF);
      send_item(FUNC_SAMPLE, 12'd4095, 16'h0000);
      send_tick(16'd2);                                // first average, slope decision
      send_item(FUNC_REARM, 12'h000, 16'h0000);        // arms hold-off
      send_item(FUNC_SAMPLE, 12'd600, 16'h1234);
      send_item(FUNC_SAMPLE, 12'd610, 16'h1234);
      send_item(FUNC_SAMPLE, 12'd620, 16'h1234);
      send_tick(16'd2);                                // repeated stamp
      send_tick(16'd65535);                            // update under hold-off
      send_item(FUNC_UNUSED, 12'hFFF, 16'hFFFF);
      send_item(FUNC_SAMPLE, 12'hAAA, 16'h5555);
      send_item(FUNC_SAMPLE, 12'h555, 16'hAAAA);
      send_item(FUNC_SAMPLE, 12'd700, 16'h0000);
      send_item(FUNC_SAMPLE, 12'd710, 16'h0000);
      send_item(FUNC_SAMPLE, 12'd720, 16'h0000);
      send_item(FUNC_SAMPLE, 12'd730, 16'h0000);
      send_item(FUNC_SAMPLE, 12'd740, 16'h0000);
      send_item(FUNC_SAMPLE, 12'd750, 16'h0000);
      send_item(FUNC_SAMPLE, 12'd760, 16'h0000);       // FIFO full: dropped
      send_tick(16'd0);
      send_item(FUNC_SAMPLE, 12'd650, 16'h0000);
   endtask

   task automatic run_random(input int n);
      int sent;
      int pick;
      int k;
      sent = 0;
      while (sent < n) begin
         pick = $urandom_range(99);
         if ($urandom_range(9) == 0) drift = int'($urandom_range(18)) - 6;
         adc_level += drift;
         if (adc_level < 200 || adc_level > 1100) adc_level = $urandom_range(500, 850);
         if ($urandom_range(49) == 0) adc_level = $urandom_range(4095);
         if (pick < 65) begin
            // a normal measurement cycle: a few samples and a fresh tick
            k = ($urandom_range(3) == 0) ? $urandom_range(1, 5) : AVG_COUNT_DEF;
            repeat (k) send_sample();
            stamp_next += STAMP_W'($urandom_range(1, 3));
            send_tick(stamp_next);
            sent += k + 1;
         end else if (pick < 73) begin
            k = $urandom_range(8, 11);
            repeat (k) send_sample();
            sent += k;
         end else if (pick < 81) begin
            send_item(FUNC_REARM, ADC_W'($urandom), STAMP_W'($urandom));
            sent++;
         end else if (pick < 87) begin
            send_tick(last_sent_stamp);
         end else if (pick < 91) begin
            send_item(FUNC_UNUSED, ADC_W'($urandom), STAMP_W'($urandom));
         end else if (pick < 96) begin
            send_item(FUNC_SAMPLE, ADC_W'($urandom), STAMP_W'($urandom));
            sent++;
         end else begin
            stamp_next = STAMP_W'($urandom);
            send_tick(stamp_next);
            sent++;
         end
      end
   endtask

   initial begin
      int phase;
      reset = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.func       = FUNC_SAMPLE;
      req_chan.adc_sample = '0;
      req_chan.tick_stamp = '0;
      csr_chan.valid      = 1'b0;
      csr_chan.index      = CSR_VOLT_GAIN;
      csr_chan.data       = '0;
      adc_level       = 650;
      drift           = 1;
      stamp_next      = 16'd100;
      last_sent_stamp = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      run_directed();
      for (phase = 0; phase < PHASES; phase++) begin
         drain();
         case (phase % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 78; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 78; end
            default: begin send_idle_pct = 25; rsp_stall_pct = 25; end
         endcase
         program_phase(phase);
         if (phase == 8) begin
            @(posedge clock);
            hold_requests++;
         end
         run_random(PHASE_ITEMS);
      end
      drain();

      if (mismatches == 0 && results_due == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

>>> files.f
design/blm_pkg.sv
design/blm_ifs.sv
design/blm_div.sv
design/battery_level_monitor.sv
design/blm_checker.sv
tb/sv/blm_checker.sv
tb/sv/tb_top.sv
